// ===== design/msgid_pkg.sv =====
// ----------------------------------------------------------------------------
// msgid_pkg
// Shared constants, codes and types of the message identifier allocator.
// ----------------------------------------------------------------------------
package msgid_pkg;

  // Size of the identifier pool. Identifier zero is reserved.
  localparam int unsigned ID_COUNT = 256;
  localparam int unsigned IDX_W    = (ID_COUNT > 2) ? $clog2(ID_COUNT) : 1;

  // Fixed widths of the transaction fields.
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned MSG_ID_W = 8;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned STATUS_W = 2;

  // Width used to range check an incoming identifier against the pool size.
  localparam int unsigned CMP_W = ((IDX_W > MSG_ID_W) ? IDX_W : MSG_ID_W) + 1;

  // The free search works on groups of identifiers.
  localparam int unsigned GRP_SIZE = 16;
  localparam int unsigned GRP_BW   = $clog2(GRP_SIZE);
  localparam int unsigned NUM_GRP  = (ID_COUNT + GRP_SIZE - 1) / GRP_SIZE;
  localparam int unsigned GRP_IW   = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
  localparam int unsigned PAD_W    = NUM_GRP * GRP_SIZE;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOCATE = 2'd0,
    ACT_RELEASE  = 2'd1,
    ACT_SET      = 2'd2,
    ACT_GET      = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_NOT_USED = 2'd2
  } status_e;

  // Outcome of the lowest free identifier search.
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } ffs_res_t;

endpackage

// ===== design/msgid_first_free.sv =====
// ----------------------------------------------------------------------------
// msgid_first_free
// Finds the lowest free identifier: a group level priority pick followed by a
// priority pick inside the chosen group.
// ----------------------------------------------------------------------------
module msgid_first_free
  import msgid_pkg::*;
(
  input  logic [PAD_W-1:0]   free_i,
  input  logic [NUM_GRP-1:0] grp_avail_i,
  output ffs_res_t           res_o
);

  logic [GRP_IW-1:0]   grp_sel;
  logic [GRP_BW-1:0]   bit_sel;
  logic                bit_found;
  logic [GRP_SIZE-1:0] grp_bits;

  // Lowest group that still holds a free identifier.
  always_comb begin
    grp_sel = '0;
    for (int g = NUM_GRP - 1; g >= 0; g--) begin
      if (grp_avail_i[g]) begin
        grp_sel = GRP_IW'(g);
      end
    end
  end

  assign grp_bits = free_i[GRP_SIZE * grp_sel +: GRP_SIZE];

  // Lowest free identifier inside that group.
  always_comb begin
    bit_sel   = '0;
    bit_found = 1'b0;
    for (int b = GRP_SIZE - 1; b >= 0; b--) begin
      if (grp_bits[b]) begin
        bit_sel   = GRP_BW'(b);
        bit_found = 1'b1;
      end
    end
  end

  assign res_o.found = bit_found;
  assign res_o.idx   = IDX_W'({grp_sel, bit_sel});

endmodule

// ===== design/message_id_allocator.sv =====
// ----------------------------------------------------------------------------
// message_id_allocator
// Allocates, releases and tags message identifiers from a fixed pool.
// ----------------------------------------------------------------------------
// Each transaction carries one action: allocate grants the lowest free
// identifier from 1 upward, release frees an identifier, set stores a 64-bit
// user word for an identifier in use and get returns it. Identifier zero is
// reserved and never granted; release, set and get on an identifier that is
// not in use (zero, beyond the pool, or free) answer "not in use" and change
// nothing. Every request transaction yields exactly one result transaction.
// A request passes an accept step and an execute step: in the accept step the
// user word RAM is read at the given identifier, and in the execute step the
// used bits are updated, the RAM is written on a set and the result register
// is loaded. The next request is accepted the cycle after execute, so the
// block takes no new request while one is still in flight; a result that
// is held back stalls the execute step until the output register frees up.
// The used bits and a per entry "written" bit sit in flops cleared by reset,
// so the user words read as zero after reset without a clearing pass; the
// user word RAM itself is never cleared.
// ----------------------------------------------------------------------------
module message_id_allocator
  import msgid_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [MSG_ID_W-1:0] msg_id_i,
  input  logic [DATA_W-1:0]   user_data_in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [MSG_ID_W-1:0] id_out_o,
  output logic [DATA_W-1:0]   user_data_out_o
);

  // Sequencer states.
  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;

  // Registered request.
  action_e             act_q;
  logic [MSG_ID_W-1:0] id_q;
  logic [DATA_W-1:0]   data_q;

  // Per identifier bookkeeping in flops.
  logic [ID_COUNT-1:0] used_q, used_d;
  logic [ID_COUNT-1:0] wr_q, wr_d;
  logic [NUM_GRP-1:0]  grp_avail_q, grp_avail_d;
  logic [PAD_W-1:0]    free_cur, free_nxt;

  // User word RAM.
  logic [DATA_W-1:0] mem [ID_COUNT];
  logic [DATA_W-1:0] mem_rd_q;
  logic              mem_we;
  logic              mem_re;
  logic [IDX_W-1:0]  rd_idx;

  // Result register.
  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, out_status_d;
  logic [MSG_ID_W-1:0] out_id_q, out_id_d;
  logic [DATA_W-1:0]   out_data_q, out_data_d;

  logic             accept;
  logic             exec_go;
  logic [CMP_W-1:0] id_ext;
  logic [IDX_W-1:0] idx;
  logic             in_use;
  ffs_res_t         ffs;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign exec_go    = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  assign rd_idx = IDX_W'(msg_id_i);
  assign mem_re = accept;

  assign id_ext = CMP_W'(id_q);
  assign idx    = IDX_W'(id_q);
  assign in_use = (id_ext < CMP_W'(ID_COUNT)) && (id_q != '0) && used_q[idx];

  // Free masks over the padded pool: the reserved identifier and the padding
  // never count as free.
  always_comb begin
    free_cur = '0;
    free_nxt = '0;
    for (int i = 1; i < ID_COUNT; i++) begin
      free_cur[i] = !used_q[i];
      free_nxt[i] = !used_d[i];
    end
  end

  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_avail_d[g] = |free_nxt[g * GRP_SIZE +: GRP_SIZE];
    end
  end

  msgid_first_free u_first_free (
    .free_i      (free_cur),
    .grp_avail_i (grp_avail_q),
    .res_o       (ffs)
  );

  // Execute step: update bookkeeping and build the result.
  always_comb begin
    used_d       = used_q;
    wr_d         = wr_q;
    mem_we       = 1'b0;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;
    out_data_d   = out_data_q;
    if (exec_go) begin
      out_status_d = ST_OK;
      out_id_d     = '0;
      out_data_d   = '0;
      if (act_q == ACT_ALLOCATE) begin
        if (ffs.found) begin
          used_d[ffs.idx] = 1'b1;
          out_id_d        = MSG_ID_W'(ffs.idx);
        end else begin
          out_status_d = ST_NO_FREE;
        end
      end else if (!in_use) begin
        out_status_d = ST_NOT_USED;
      end else begin
        unique case (act_q)
          ACT_RELEASE: begin
            used_d[idx] = 1'b0;
          end
          ACT_SET: begin
            mem_we    = 1'b1;
            wr_d[idx] = 1'b1;
          end
          ACT_GET: begin
            out_data_d = wr_q[idx] ? mem_rd_q : '0;
          end
          default: begin
            out_status_d = ST_OK;
          end
        endcase
      end
    end
  end

  always_comb begin
    unique case (state_q)
      S_IDLE:  state_d = accept ? S_EXEC : S_IDLE;
      S_EXEC:  state_d = exec_go ? S_IDLE : S_EXEC;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (exec_go) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      used_q      <= '0;
      wr_q        <= '0;
      grp_avail_q <= '1;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      used_q      <= used_d;
      wr_q        <= wr_d;
      grp_avail_q <= grp_avail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q  <= action_e'(action_i);
      id_q   <= msg_id_i;
      data_q <= user_data_in_i;
    end
    out_status_q <= out_status_d;
    out_id_q     <= out_id_d;
    out_data_q   <= out_data_d;
  end

  // User word RAM: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[idx] <= data_q;
    end
    if (mem_re) begin
      mem_rd_q <= mem[rd_idx];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign id_out_o        = out_id_q;
  assign user_data_out_o = out_data_q;

  // A granted identifier is marked used right after the grant.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_go && act_q == ACT_ALLOCATE && ffs.found) |=> used_q[$past(ffs.idx)])
    else $error("granted identifier not marked used");

  // The RAM is written only for an identifier in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (used_q[idx] && id_q != '0))
    else $error("user word written for an identifier not in use");

  // A new result appears only after an execute step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EXEC))
    else $error("result raised without an execute step");

  // The reserved identifier is never marked used.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_go |=> !used_q[0])
    else $error("reserved identifier marked used");

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the message identifier allocator.
// ----------------------------------------------------------------------------
// A short table of directed requests covers reset contents, the reserved
// identifier, double release, reuse of the lowest free identifier and user
// words that survive a release. A long random run follows, in which the
// stream alternates between filling the pool past exhaustion and draining it.
// Every accepted request is run through a behavioral shadow of the identifier
// pool, and each response is compared field by field, in order, with the
// prediction.
// ----------------------------------------------------------------------------
module testbench;
  import msgid_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One expected response transaction.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [MSG_ID_W-1:0] id;
    logic [DATA_W-1:0]   data;
  } response_t;

  // One row of the directed table. Where known is set, the response is typed
  // in by hand; otherwise it comes from the shadow pool.
  typedef struct packed {
    action_e             act;
    logic [MSG_ID_W-1:0] id;
    logic [DATA_W-1:0]   data;
    logic                known;
    response_t           rsp;
  } dir_row_t;

  localparam int unsigned N_DIR      = 25;
  localparam int unsigned N_RANDOM   = 1100;
  localparam int unsigned HOLD_CYC   = 300;
  localparam logic [63:0] ONES       = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] EDGE_WORD  = 64'h8000_0000_0000_0001;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [ACTION_W-1:0] action;
  logic [MSG_ID_W-1:0] msg_id;
  logic [DATA_W-1:0]   user_data_in;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] status;
  logic [MSG_ID_W-1:0] id_out;
  logic [DATA_W-1:0]   user_data_out;

  // Shadow of the identifier pool: one used bit and one user word per entry.
  bit                  id_busy [ID_COUNT];
  logic [DATA_W-1:0]   id_word [ID_COUNT];

  response_t           pending_responses [$];
  int unsigned         error_count;

  // Flow control knobs of the request and response sides; the idle knobs are in
  // percent of cycles spent idle.
  int unsigned         sender_idle_pct;
  int unsigned         receiver_idle_pct;
  bit                  hold_off_req;

  // Random stream direction: grow the pool toward exhaustion, or shrink it.
  bit                  filling;

  message_id_allocator DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .action_i        (action),
    .msg_id_i        (msg_id),
    .user_data_in_i  (user_data_in),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .status_o        (status),
    .id_out_o        (id_out),
    .user_data_out_o (user_data_out)
  );

  // Directed table. Reset state is empty, so the first grants are 1, 2, 3.
  // After identifier 2 is released, the next allocate must reuse it, and
  // identifier 1 still returns its old word after a release and regrant.
  dir_row_t dir_rows [N_DIR] = '{
    '{ACT_GET,      8'd5,   64'd0,     1'b1, '{ST_NOT_USED, 8'd0, 64'd0}},
    '{ACT_RELEASE,  8'd0,   64'd0,     1'b1, '{ST_NOT_USED, 8'd0, 64'd0}},
    '{ACT_SET,      8'd255, ONES,      1'b1, '{ST_NOT_USED, 8'd0, 64'd0}},
    '{ACT_ALLOCATE, 8'd255, ONES,      1'b1, '{ST_OK,       8'd1, 64'd0}},
    '{ACT_ALLOCATE, 8'd0,   64'd0,     1'b1, '{ST_OK,       8'd2, 64'd0}},
    '{ACT_ALLOCATE, 8'd7,   64'd0,     1'b1, '{ST_OK,       8'd3, 64'd0}},
    '{ACT_SET,      8'd1,   ONES,      1'b1, '{ST_OK,       8'd0, 64'd0}},
    '{ACT_GET,      8'd1,   64'd0,     1'b1, '{ST_OK,       8'd0, ONES}},
    '{ACT_SET,      8'd2,   64'd0,     1'b1, '{ST_OK,       8'd0, 64'd0}},
    '{ACT_GET,      8'd2,   ONES,      1'b1, '{ST_OK,       8'd0, 64'd0}},
    '{ACT_SET,      8'd3,   EDGE_WORD, 1'b1, '{ST_OK,       8'd0, 64'd0}},
    '{ACT_GET,      8'd3,   64'd0,     1'b1, '{ST_OK,       8'd0, EDGE_WORD}},
    '{ACT_SET,      8'd0,   ONES,      1'b1, '{ST_NOT_USED, 8'd0, 64'd0}},
    '{ACT_GET,      8'd0,   64'd0,     1'b1, '{ST_NOT_USED, 8'd0, 64'd0}},
    '{ACT_RELEASE,  8'd2,   64'd0,     1'b1, '{ST_OK,       8'd0, 64'd0}},
    '{ACT_RELEASE,  8'd2,   64'd0,     1'b1, '{ST_NOT_USED, 8'd0, 64'd0}},
    '{ACT_GET,      8'd2,   64'd0,     1'b1, '{ST_NOT_USED, 8'd0, 64'd0}},
    '{ACT_SET,      8'd2,   ONES,      1'b1, '{ST_NOT_USED, 8'd0, 64'd0}},
    '{ACT_ALLOCATE, 8'd128, 64'd0,     1'b1, '{ST_OK,       8'd2, 64'd0}},
    '{ACT_GET,      8'd2,   64'd0,     1'b1, '{ST_OK,       8'd0, 64'd0}},
    '{ACT_RELEASE,  8'd1,   64'd0,     1'b1, '{ST_OK,       8'd0, 64'd0}},
    '{ACT_ALLOCATE, 8'd0,   64'd0,     1'b1, '{ST_OK,       8'd1, 64'd0}},
    '{ACT_GET,      8'd1,   64'd0,     1'b1, '{ST_OK,       8'd0, ONES}},
    '{ACT_ALLOCATE, 8'd0,   64'd0,     1'b0, '{ST_OK,       8'd0, 64'd0}},
    '{ACT_GET,      8'd255, 64'd0,     1'b1, '{ST_NOT_USED, 8'd0, 64'd0}}
  };

  // Free-running clock with an 8 ns period.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Shadow of one request: updates the pool and returns the response the
  // block must give for it.
  function automatic response_t pool_response(action_e act, logic [MSG_ID_W-1:0] id,
                                              logic [DATA_W-1:0] data);
    response_t rsp;
    bit        in_use;
    rsp    = '{ST_OK, '0, '0};
    in_use = (id != '0) && (int'(id) < ID_COUNT) && id_busy[int'(id)];
    if (act == ACT_ALLOCATE) begin
      // Lowest free identifier from 1 upward; the reserved zero is skipped.
      rsp.status = ST_NO_FREE;
      for (int i = 1; i < ID_COUNT; i++) begin
        if (!id_busy[i]) begin
          id_busy[i] = 1'b1;
          rsp.status = ST_OK;
          rsp.id     = i[MSG_ID_W-1:0];
          break;
        end
      end
    end else if (!in_use) begin
      rsp.status = ST_NOT_USED;
    end else if (act == ACT_RELEASE) begin
      // The user word stays in place; only reset clears it.
      id_busy[int'(id)] = 1'b0;
    end else if (act == ACT_SET) begin
      id_word[int'(id)] = data;
    end else begin
      rsp.data = id_word[int'(id)];
    end
    return rsp;
  endfunction

  function automatic int unsigned busy_count();
    int unsigned n;
    n = 0;
    for (int i = 0; i < ID_COUNT; i++) n += id_busy[i];
    return n;
  endfunction

  // A random identifier that is currently in use, or any identifier at all
  // when the pool is empty.
  function automatic logic [MSG_ID_W-1:0] pick_busy_id();
    int q [$];
    for (int i = 1; i < ID_COUNT; i++) begin
      if (id_busy[i]) q.push_back(i);
    end
    if (q.size() == 0) return MSG_ID_W'($urandom_range(0, 255));
    return MSG_ID_W'(q[$urandom_range(0, q.size() - 1)]);
  endfunction

  // Offers one request on the falling edge and holds it until the block takes
  // it. The response is predicted at the accepting edge, so the next request
  // is generated from the updated pool. Valid is left high on return so that
  // back-to-back transactions need no second assignment in the same step.
  task automatic send_request(action_e act, logic [MSG_ID_W-1:0] id,
                              logic [DATA_W-1:0] data, bit known, response_t typed_rsp);
    response_t rsp;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    msg_id       <= id;
    user_data_in <= data;
    do @(posedge clk); while (!in_ready);
    rsp = pool_response(act, id, data);
    pending_responses.push_back(known ? typed_rsp : rsp);
    @(negedge clk);
  endtask

  // One random request. Most requests are well formed: while filling, mostly
  // allocates; while draining, mostly releases of identifiers in use. About a
  // fifth of the non-allocate requests target an arbitrary identifier, which
  // exercises the reserved zero and free entries.
  task automatic send_random_request();
    action_e             act;
    logic [MSG_ID_W-1:0] id;
    int unsigned         roll;
    int unsigned         n_busy;
    n_busy = busy_count();
    if (filling && n_busy == ID_COUNT - 1 && $urandom_range(0, 7) == 0) begin
      filling = 1'b0;
    end else if (!filling && n_busy <= 3) begin
      filling = 1'b1;
    end
    roll = $urandom_range(0, 99);
    if (filling) begin
      if (roll < 78)      act = ACT_ALLOCATE;
      else if (roll < 86) act = ACT_SET;
      else if (roll < 94) act = ACT_GET;
      else                act = ACT_RELEASE;
    end else begin
      if (roll < 72)      act = ACT_RELEASE;
      else if (roll < 84) act = ACT_SET;
      else if (roll < 96) act = ACT_GET;
      else                act = ACT_ALLOCATE;
    end
    id = MSG_ID_W'($urandom_range(0, 255));
    if (act != ACT_ALLOCATE && $urandom_range(0, 99) < 80) id = pick_busy_id();
    send_request(act, id, {$urandom, $urandom}, 1'b0, '{ST_OK, '0, '0});
  endtask

  // Response side. Ready is redrawn on every falling edge outside a hold-off.
  // A hold-off request keeps ready low for a long stretch, so the block backs up
  // and stalls its request channel while the sender keeps offering.
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYC) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
    end
  end

  // Response checker: every accepted response is matched against the oldest
  // prediction.
  always @(posedge clk) begin
    response_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_responses.size() == 0) begin
        $display("%0t: unexpected response status=%0d id=%0d data=%h",
                 $realtime, status, id_out, user_data_out);
        error_count++;
      end else begin
        want = pending_responses.pop_front();
        if (status !== want.status || id_out !== want.id || user_data_out !== want.data) begin
          $display("%0t: mismatch expected status=%0d id=%0d data=%h, got status=%0d id=%0d data=%h",
                   $realtime, want.status, want.id, want.data, status, id_out, user_data_out);
          error_count++;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Main sequence: reset, directed table, then three random phases with
  // different flow control, and finally the drain of outstanding responses.
  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    action            = ACT_ALLOCATE;
    msg_id            = '0;
    user_data_in      = '0;
    error_count       = 0;
    hold_off_req      = 1'b0;
    filling           = 1'b1;
    sender_idle_pct   = 36;
    receiver_idle_pct = 87;
    for (int i = 0; i < ID_COUNT; i++) begin
      id_busy[i] = 1'b0;
      id_word[i] = '0;
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].act, dir_rows[i].id, dir_rows[i].data,
                   dir_rows[i].known, dir_rows[i].rsp);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct   = 36;
          receiver_idle_pct = 87;
        end
        1: begin
          sender_idle_pct   = 87;
          receiver_idle_pct = 36;
        end
        default: begin
          // No idling on either side, but first a long receiver hold-off
          // while requests keep coming.
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
          hold_off_req      = 1'b1;
        end
      endcase
      for (int n = 0; n < N_RANDOM / 3; n++) send_random_request();
    end
    in_valid <= 1'b0;

    while (pending_responses.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
